>>> sv/ncdf_pkg.sv
package ncdf_pkg;

   localparam int IN_FRAC_BITS_DEF = 12;
   localparam int OUT_BITS_DEF     = 16;
   localparam int X_W              = 16;
   localparam int TAYLOR_TERMS     = 12;
   localparam int DIV_STEPS        = 31;
   localparam int HORNER_STEPS     = 5;

   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [31:0] INV_SQRT2 = 32'd3037000500;
   localparam logic [47:0] Z_LIMIT   = 48'd6 << 32;

   // ceil(2^k * c): floor(v * c) == (v * recip) >> k over the ranges used here
   localparam logic [127:0] P_RECIP_FULL =
      ((128'd1 << 64) * 128'd3275911 + 128'd9999999) / 128'd10000000;
   localparam logic [127:0] L2E_RECIP_FULL =
      ((128'd1 << 64) * 128'd442695041 + 128'd999999999) / 128'd1000000000;
   localparam logic [127:0] LN2_RECIP_FULL =
      ((128'd1 << 62) * 128'd693147181 + 128'd999999999) / 128'd1000000000;
   localparam logic [62:0] P_RECIP   = P_RECIP_FULL[62:0];
   localparam logic [62:0] L2E_RECIP = L2E_RECIP_FULL[62:0];
   localparam logic [61:0] LN2_RECIP = LN2_RECIP_FULL[61:0];

   localparam logic [63:0] TAY_ONE = 64'd1 << 36;
   // ceil(2^36 / n) for n = 1..12
   localparam logic [36:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
      37'((TAY_ONE + 64'd0) / 64'd1),   37'((TAY_ONE + 64'd1) / 64'd2),
      37'((TAY_ONE + 64'd2) / 64'd3),   37'((TAY_ONE + 64'd3) / 64'd4),
      37'((TAY_ONE + 64'd4) / 64'd5),   37'((TAY_ONE + 64'd5) / 64'd6),
      37'((TAY_ONE + 64'd6) / 64'd7),   37'((TAY_ONE + 64'd7) / 64'd8),
      37'((TAY_ONE + 64'd8) / 64'd9),   37'((TAY_ONE + 64'd9) / 64'd10),
      37'((TAY_ONE + 64'd10) / 64'd11), 37'((TAY_ONE + 64'd11) / 64'd12)
   };

   // a1..a5 in q30, truncated toward zero
   localparam logic signed [32:0] COEF_A [HORNER_STEPS] = '{
      33'(64'sd254829592 * 64'sd1073741824 / 64'sd1000000000),
      33'((-64'sd284496736) * 64'sd1073741824 / 64'sd1000000000),
      33'(64'sd1421413741 * 64'sd1073741824 / 64'sd1000000000),
      33'((-64'sd1453152027) * 64'sd1073741824 / 64'sd1000000000),
      33'(64'sd1061405429 * 64'sd1073741824 / 64'sd1000000000)
   };

   typedef struct packed {
      logic               neg;
      logic               big;
      logic [33:0]        denom;
      logic [6:0]         kexp;
      logic [29:0]        g;
      logic [30:0]        tmag;
      logic [60:0]        tprod;
      logic [66:0]        tquo;
      logic signed [31:0] sum;
   } tay_type;

   typedef struct packed {
      logic        neg;
      logic        big;
      logic [33:0] denom;
      logic [30:0] e;
      logic [33:0] rem;
      logic [30:0] quo;
   } div_type;

   typedef struct packed {
      logic               neg;
      logic               big;
      logic [30:0]        e;
      logic [30:0]        t;
      logic signed [32:0] acc;
      logic signed [64:0] hprod;
   } hor_type;

endpackage

>>> sv/normal_cdf_approximation.sv
// throughput: one transaction per cycle; the pipeline stalls only when the
//   output register and the skid register both hold results
// the depth is set by the 31-stage restoring divider for t and the 36-stage exp series
// reset: synchronous, active high; clears all valid bits, payload is not reset
module normal_cdf_approximation #(
   parameter int IN_FRAC_BITS = ncdf_pkg::IN_FRAC_BITS_DEF,
   parameter int OUT_BITS     = ncdf_pkg::OUT_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ncdf_pkg::X_W-1:0]               req_tdata,  // [15:0] x_value
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((OUT_BITS + 7) / 8) * 8 - 1:0]  rsp_tdata   // [OUT_BITS-1:0] probability
);
   import ncdf_pkg::*;

   localparam int RSP_W = ((OUT_BITS + 7) / 8) * 8;
   localparam int RND_W = 31 + OUT_BITS + 1;
   localparam int TAY_N = 3 * TAYLOR_TERMS;
   localparam int HOR_N = 2 * HORNER_STEPS;
   localparam logic [OUT_BITS-1:0] MAXV = '1;

   logic en;
   logic out_v_ff, skid_v_ff;
   logic [OUT_BITS-1:0] out_ff, skid_ff;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   // front end: magnitude, z, denominator, z^2 and the reduction of exp(-z^2) to 2^-k * exp(-g)
   logic        f1_v_ff, f2_v_ff, f3_v_ff, f4_v_ff, f5_v_ff, f6_v_ff, f7_v_ff, f8_v_ff;
   logic        f1_neg_ff, f2_neg_ff, f3_neg_ff, f4_neg_ff;
   logic        f5_neg_ff, f6_neg_ff, f7_neg_ff, f8_neg_ff;
   logic        f3_big_ff, f4_big_ff, f5_big_ff, f6_big_ff, f7_big_ff, f8_big_ff;
   logic [15:0] f1_mag_ff, f1_mag_in;
   logic [47:0] f2_prod_ff, f3_z48_in;
   logic [34:0] f3_z_ff;
   logic [66:0] f4_zlo_ff;
   logic [65:0] f4_zhi_ff;
   logic [37:0] f4_zsq_ff;
   logic [97:0] f5_zp_in;
   logic [33:0] f5_denom_ff, f6_denom_ff, f7_denom_ff, f8_denom_ff, f5_zz_ff, f6_zz_ff;
   logic [65:0] f6_ulo_ff;
   logic [64:0] f6_uhi_ff;
   logic [96:0] f7_up_in;
   logic [34:0] f7_u_in;
   logic [6:0]  f7_kexp_ff, f8_kexp_ff;
   logic [27:0] f7_frac_ff;
   logic [61:0] f8_glo_ff;
   logic [59:0] f8_ghi_ff;

   assign f1_mag_in = req_tdata[X_W-1] ? 16'(-req_tdata) : req_tdata;
   assign f3_z48_in = f2_prod_ff >> IN_FRAC_BITS;
   assign f5_zp_in  = (98'(f4_zhi_ff) << 32) + 98'(f4_zlo_ff);
   assign f7_up_in  = (97'(f6_uhi_ff) << 32) + 97'(f6_ulo_ff);
   assign f7_u_in   = 35'(f6_zz_ff) + 35'(f7_up_in >> 64);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0; f2_v_ff <= 1'b0; f3_v_ff <= 1'b0; f4_v_ff <= 1'b0;
         f5_v_ff <= 1'b0; f6_v_ff <= 1'b0; f7_v_ff <= 1'b0; f8_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= req_tvalid; f2_v_ff <= f1_v_ff; f3_v_ff <= f2_v_ff; f4_v_ff <= f3_v_ff;
         f5_v_ff <= f4_v_ff; f6_v_ff <= f5_v_ff; f7_v_ff <= f6_v_ff; f8_v_ff <= f7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_neg_ff   <= req_tdata[X_W-1];
         f1_mag_ff   <= f1_mag_in;
         f2_neg_ff   <= f1_neg_ff;
         f2_prod_ff  <= 48'(f1_mag_ff) * 48'(INV_SQRT2);
         f3_neg_ff   <= f2_neg_ff;
         f3_big_ff   <= f3_z48_in >= Z_LIMIT;
         f3_z_ff     <= f3_z48_in[34:0];
         f4_neg_ff   <= f3_neg_ff;
         f4_big_ff   <= f3_big_ff;
         f4_zlo_ff   <= 67'(f3_z_ff) * 67'(P_RECIP[31:0]);
         f4_zhi_ff   <= 66'(f3_z_ff) * 66'(P_RECIP[62:32]);
         f4_zsq_ff   <= 38'(f3_z_ff[34:16]) * 38'(f3_z_ff[34:16]);
         f5_neg_ff   <= f4_neg_ff;
         f5_big_ff   <= f4_big_ff;
         f5_denom_ff <= 34'(f5_zp_in >> 64) + 34'h1_0000_0000;
         f5_zz_ff    <= f4_zsq_ff[37:4];
         f6_neg_ff   <= f5_neg_ff;
         f6_big_ff   <= f5_big_ff;
         f6_denom_ff <= f5_denom_ff;
         f6_zz_ff    <= f5_zz_ff;
         f6_ulo_ff   <= 66'(f5_zz_ff) * 66'(L2E_RECIP[31:0]);
         f6_uhi_ff   <= 65'(f5_zz_ff) * 65'(L2E_RECIP[62:32]);
         f7_neg_ff   <= f6_neg_ff;
         f7_big_ff   <= f6_big_ff;
         f7_denom_ff <= f6_denom_ff;
         f7_kexp_ff  <= f7_u_in[34:28];
         f7_frac_ff  <= f7_u_in[27:0];
         f8_neg_ff   <= f7_neg_ff;
         f8_big_ff   <= f7_big_ff;
         f8_denom_ff <= f7_denom_ff;
         f8_kexp_ff  <= f7_kexp_ff;
         f8_glo_ff   <= 62'({f7_frac_ff, 2'b00}) * 62'(LN2_RECIP[31:0]);
         f8_ghi_ff   <= 60'({f7_frac_ff, 2'b00}) * 60'(LN2_RECIP[61:32]);
      end
   end

   // exp(-g) series, three stages per term: product, divide by n, accumulate
   tay_type tay_ff [TAY_N+1];
   tay_type tay_in [TAY_N+1];
   logic    tay_v_ff [TAY_N+1];
   logic [91:0] tay_gp;

   assign tay_gp = (92'(f8_ghi_ff) << 32) + 92'(f8_glo_ff);

   always_comb begin
      tay_in[0]       = '0;
      tay_in[0].neg   = f8_neg_ff;
      tay_in[0].big   = f8_big_ff;
      tay_in[0].denom = f8_denom_ff;
      tay_in[0].kexp  = f8_kexp_ff;
      tay_in[0].g     = 30'(tay_gp >> 62);
      tay_in[0].tmag  = Q30_ONE;
      tay_in[0].sum   = 32'sh4000_0000;
   end

   for (genvar n = 1; n <= TAYLOR_TERMS; n++) begin : g_tay
      always_comb begin
         tay_in[3*n-2]       = tay_ff[3*n-3];
         tay_in[3*n-2].tprod = 61'(tay_ff[3*n-3].tmag) * 61'(tay_ff[3*n-3].g);
         tay_in[3*n-1]       = tay_ff[3*n-2];
         tay_in[3*n-1].tquo  = 67'(tay_ff[3*n-2].tprod[60:30]) * 67'(TAYLOR_RECIP[n-1]);
         tay_in[3*n]         = tay_ff[3*n-1];
         tay_in[3*n].tmag    = 31'(tay_ff[3*n-1].tquo >> 36);
         // terms alternate in sign: odd terms subtract
         if (n % 2 == 1) begin
            tay_in[3*n].sum = tay_ff[3*n-1].sum - $signed({1'b0, tay_in[3*n].tmag});
         end else begin
            tay_in[3*n].sum = tay_ff[3*n-1].sum + $signed({1'b0, tay_in[3*n].tmag});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= TAY_N; i++) tay_v_ff[i] <= 1'b0;
      end else if (en) begin
         tay_v_ff[0] <= f8_v_ff;
         for (int i = 1; i <= TAY_N; i++) tay_v_ff[i] <= tay_v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= TAY_N; i++) tay_ff[i] <= tay_in[i];
      end
   end

   // restoring divider for t = 2^62 / denom, one quotient bit per stage
   div_type div_ff [DIV_STEPS+1];
   div_type div_in [DIV_STEPS+1];
   logic    div_v_ff [DIV_STEPS+1];
   logic [30:0] exp_sum_c;

   assign exp_sum_c = tay_ff[TAY_N].sum[31] ? 31'd0 : tay_ff[TAY_N].sum[30:0];

   always_comb begin
      div_in[0]       = '0;
      div_in[0].neg   = tay_ff[TAY_N].neg;
      div_in[0].big   = tay_ff[TAY_N].big;
      div_in[0].denom = tay_ff[TAY_N].denom;
      div_in[0].e     = (tay_ff[TAY_N].kexp >= 7'd31) ? 31'd0 : exp_sum_c >> tay_ff[TAY_N].kexp;
      div_in[0].rem   = 34'h0_8000_0000;
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
      logic [34:0] r2;
      logic        qb;
      assign r2 = {div_ff[j-1].rem, 1'b0};
      assign qb = r2 >= {1'b0, div_ff[j-1].denom};
      always_comb begin
         div_in[j]     = div_ff[j-1];
         div_in[j].rem = qb ? 34'(r2 - {1'b0, div_ff[j-1].denom}) : r2[33:0];
         div_in[j].quo = {div_ff[j-1].quo[29:0], qb};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) div_v_ff[i] <= 1'b0;
      end else if (en) begin
         div_v_ff[0] <= tay_v_ff[TAY_N];
         for (int i = 1; i <= DIV_STEPS; i++) div_v_ff[i] <= div_v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= DIV_STEPS; i++) div_ff[i] <= div_in[i];
      end
   end

   // horner polynomial in t, multiply then truncate-and-add per step
   hor_type hor_ff [HOR_N+1];
   hor_type hor_in [HOR_N+1];
   logic    hor_v_ff [HOR_N+1];

   always_comb begin
      hor_in[0]     = '0;
      hor_in[0].neg = div_ff[DIV_STEPS].neg;
      hor_in[0].big = div_ff[DIV_STEPS].big;
      hor_in[0].e   = div_ff[DIV_STEPS].e;
      hor_in[0].t   = div_ff[DIV_STEPS].quo;
      hor_in[0].acc = COEF_A[HORNER_STEPS-1];
   end

   for (genvar s = 1; s <= HORNER_STEPS; s++) begin : g_hor
      logic signed [64:0] a_ext, t_ext, hb, hq;
      logic signed [32:0] cf;
      assign a_ext = hor_ff[2*s-2].acc;
      assign t_ext = $signed({34'b0, hor_ff[2*s-2].t});
      // truncate toward zero
      assign hb = hor_ff[2*s-1].hprod
                + (hor_ff[2*s-1].hprod[64] ? 65'sd1073741823 : 65'sd0);
      assign hq = hb >>> 30;
      if (s < HORNER_STEPS) begin : g_cf
         assign cf = COEF_A[HORNER_STEPS-1-s];
      end else begin : g_nocf
         assign cf = '0;
      end
      always_comb begin
         hor_in[2*s-1]       = hor_ff[2*s-2];
         hor_in[2*s-1].hprod = a_ext * t_ext;
         hor_in[2*s]         = hor_ff[2*s-1];
         hor_in[2*s].acc     = hq[32:0] + cf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= HOR_N; i++) hor_v_ff[i] <= 1'b0;
      end else if (en) begin
         hor_v_ff[0] <= div_v_ff[DIV_STEPS];
         for (int i = 1; i <= HOR_N; i++) hor_v_ff[i] <= hor_v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= HOR_N; i++) hor_ff[i] <= hor_in[i];
      end
   end

   // erf, cdf and output rounding
   logic               fm_v_ff, fy_v_ff;
   logic               fm_neg_ff, fm_big_ff, fy_neg_ff;
   logic [62:0]        fm_prod_ff;
   logic [31:0]        fm_acc_c;
   logic signed [34:0] fy_ys;
   logic [30:0]        fy_y, fy_cdf_ff;
   logic [31:0]        fy_sum;
   logic [RND_W-1:0]   rnd, rnd_sh;
   logic [OUT_BITS-1:0] res_in;

   assign fm_acc_c = hor_ff[HOR_N].acc[32] ? 32'd0 : hor_ff[HOR_N].acc[31:0];
   assign fy_ys    = 35'sh4000_0000 - $signed({2'b00, fm_prod_ff[62:30]});
   always_comb begin
      if (fm_big_ff) begin
         fy_y = Q30_ONE;
      end else if (fy_ys[34]) begin
         fy_y = '0;
      end else begin
         fy_y = fy_ys[30:0];
      end
   end
   assign fy_sum = fm_neg_ff ? 32'(Q30_ONE) - 32'(fy_y) : 32'(Q30_ONE) + 32'(fy_y);
   assign rnd    = (RND_W'(fy_cdf_ff) << OUT_BITS) + (RND_W'(1) << 29);
   assign rnd_sh = rnd >> 30;
   assign res_in = (rnd_sh > RND_W'(MAXV)) ? MAXV : rnd_sh[OUT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fm_v_ff <= 1'b0;
         fy_v_ff <= 1'b0;
      end else if (en) begin
         fm_v_ff <= hor_v_ff[HOR_N];
         fy_v_ff <= fm_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fm_neg_ff  <= hor_ff[HOR_N].neg;
         fm_big_ff  <= hor_ff[HOR_N].big;
         fm_prod_ff <= 63'(fm_acc_c) * 63'(hor_ff[HOR_N].e);
         fy_neg_ff  <= fm_neg_ff;
         fy_cdf_ff  <= fy_sum[31:1];
      end
   end

   // output register with skid stage
   logic pop, push;
   assign pop  = out_v_ff && rsp_tready;
   assign push = en && fy_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (!out_v_ff || pop) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (!out_v_ff || pop) out_ff <= skid_ff;
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RSP_W'(out_ff);

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register full while output register empty");

   a_frozen_on_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(fy_v_ff) && $stable(f1_v_ff))
      else $error("pipeline moved while skid register full");

   a_big_positive_sat: assert property (@(posedge clock) disable iff (reset)
      fy_v_ff && !fy_neg_ff && fy_cdf_ff == Q30_ONE |-> res_in == MAXV)
      else $error("cdf of one did not saturate");

endmodule

>>> dv/normal_cdf_checker.sv
`timescale 1ns / 1ps
module normal_cdf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   localparam longint Q30 = 64'sd1073741824;
   localparam int IN_FRAC = 12;
   localparam int OUT_W   = 16;

   logic [15:0] prob_queue [$];

   function automatic longint coef_q30(longint d);
      return (d * Q30) / 64'sd1000000000;
   endfunction

   function automatic longint exp_neg(longint unsigned w28);
      longint unsigned u, k, f;
      longint g, term, sum;
      u = w28 + (w28 * 64'd442695041) / 64'd1000000000;
      k = u >> 28;
      f = u & ((64'd1 << 28) - 1);
      g = longint'(((f << 2) * 64'd693147181) / 64'd1000000000);
      term = Q30;
      sum = Q30;
      for (int n = 1; n <= 12; n++) begin
         term = -((term * g) / (n * Q30));
         sum += term;
      end
      if (sum < 0) sum = 0;
      if (k >= 31) return 0;
      return longint'(longint'(sum) >>> k);
   endfunction

   function automatic logic [15:0] cdf_of(logic [15:0] raw);
      logic neg;
      longint unsigned mag, z, denom, cdf, res, zh;
      longint t, acc, e, y;
      neg = raw[15];
      mag = neg ? (64'h10000 - raw) : raw;
      z = (mag * 64'd3037000500) >> IN_FRAC;
      if (z >= (64'd6 << 32)) begin
         y = Q30;
      end else begin
         denom = (64'd1 << 32) + (z * 64'd327591100) / 64'd1000000000;
         t = longint'((64'd1 << 62) / denom);
         acc = coef_q30(1061405429);
         acc = (acc * t) / Q30 + coef_q30(-1453152027);
         acc = (acc * t) / Q30 + coef_q30(1421413741);
         acc = (acc * t) / Q30 + coef_q30(-284496736);
         acc = (acc * t) / Q30 + coef_q30(254829592);
         acc = (acc * t) / Q30;
         if (acc < 0) acc = 0;
         zh = z >> 16;
         e = exp_neg((zh * zh) >> 4);
         y = Q30 - (acc * e) / Q30;
         if (y < 0) y = 0;
         if (y > Q30) y = Q30;
      end
      cdf = neg ? longint'(Q30 - y) / 2 : longint'(Q30 + y) / 2;
      res = ((cdf << OUT_W) + (64'd1 << 29)) >> 30;
      if (res > 64'hFFFF) res = 64'hFFFF;
      return res[15:0];
   endfunction

   assign pending_count = prob_queue.size();

   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) prob_queue.push_back(cdf_of(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (prob_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = prob_queue.pop_front();
               if (want !== rsp_tdata) begin
                  $display("%0t: probability mismatch, expected %0d, actual %0d",
                           $time, want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> dv/tb_normal_cdf_approximation.sv
`timescale 1ns / 1ps
module tb_normal_cdf_approximation;
   localparam int RANDOM_ITEMS = 1600;
   localparam int STALL_LIMIT  = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   int          fail_count, pending_count;
   int          idle_pct = 24;
   int          quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   normal_cdf_approximation dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   normal_cdf_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .pending_count
   );

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_x(input logic [15:0] x);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [15:0] pick_x();
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(8191)) - 4096);
         2: return 16'($signed($urandom_range(32767)) - 16384);
         3: return 16'($urandom_range(15) - 8);
         4: return 16'($signed($urandom_range(4000)) + 28767);
         default: return 16'($signed($urandom_range(24575)) - 12288);
      endcase
   endfunction

   initial begin
      logic [15:0] corner [] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
         16'h8001, 16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h4000, 16'hC000,
         16'h6000, 16'hA000, 16'h87A0, 16'h7880, 16'h5555, 16'hAAAA, 16'h0800,
         16'hF800};
      int wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (corner[i]) send_x(corner[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a stretch with no idling on either side
         idle_pct <= (n >= 600 && n < 900) ? 0 : 24;
         send_x(pick_x());
      end
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
